/* src/icdv_pkg.sv */
// Shared types and constants for the IPv4, CIDR and hostname syntax checker.
`default_nettype none

package icdv_pkg;

    localparam int MAX_NAME_LEN_DEF  = 253;
    localparam int MAX_LABEL_LEN_DEF = 63;

    localparam int CHAR_W     = 8;
    localparam int OCTET_W    = 10;
    localparam int PREFIX_W   = 6;
    localparam int ADDR_W     = 32;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CHAR_W-1:0] CHAR_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_LC_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UC_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z   = 8'h5A;

    localparam logic [1:0] CLS_LETTER = 2'd0;
    localparam logic [1:0] CLS_DIGIT  = 2'd1;
    localparam logic [1:0] CLS_HYPHEN = 2'd2;
    localparam logic [1:0] CLS_STAR   = 2'd3;

    localparam logic [PREFIX_W-1:0] FULL_PREFIX = 6'd32;
    localparam logic [3:0]          MAX_OCTET_DIGITS = 4'd3;

    typedef struct packed {
        logic              step;
        logic              last;
        logic [CHAR_W-1:0] char_code;
    } step_t;

    typedef struct packed {
        logic                is_ipv4;
        logic                is_ipv4_cidr;
        logic                prefix_given;
        logic [PREFIX_W-1:0] prefix_length;
        logic                host_bits_clear;
        logic [ADDR_W-1:0]   address_value;
    } ip_result_t;

    typedef struct packed {
        logic is_domain;
        logic is_wildcard_domain;
    } name_result_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_0) && (c <= CHAR_9);
    endfunction

endpackage

`default_nettype wire

/* src/icdv_ip_unit.sv */
// Dotted-quad address and prefix tracker with its end-of-string verdict.
`default_nettype none

module icdv_ip_unit
    import icdv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire step_t      ctrl,
    output ip_result_t      result
);

    logic                ip_ok_reg, ip_ok_next;
    logic [1:0]          octet_index_reg, octet_index_next;
    logic [1:0]          digit_count_reg, digit_count_next;
    logic [OCTET_W-1:0]  octet_accum_reg, octet_accum_next;
    logic [ADDR_W-1:0]   packed_reg, packed_next;
    logic                in_prefix_reg, in_prefix_next;
    logic [PREFIX_W-1:0] prefix_accum_reg, prefix_accum_next;

    logic [CHAR_W-1:0]   diff;
    logic [3:0]          digit;
    logic [11:0]         octet_sum;
    logic [6:0]          prefix_sum;
    logic                plain;
    logic                cidr;
    logic [ADDR_W-1:0]   addr;
    logic [PREFIX_W-1:0] plen;
    logic [PREFIX_W-1:0] shamt;
    logic [ADDR_W-1:0]   host_mask;
    logic                clear;

    assign diff       = ctrl.char_code - CHAR_0;
    assign digit      = diff[3:0];
    assign octet_sum  = 12'(octet_accum_reg) * 12'd10 + 12'(digit);
    assign prefix_sum = 7'(prefix_accum_reg) * 7'd10 + 7'(digit);

    always_comb
    begin
        ip_ok_next        = ip_ok_reg;
        octet_index_next  = octet_index_reg;
        digit_count_next  = digit_count_reg;
        octet_accum_next  = octet_accum_reg;
        packed_next       = packed_reg;
        in_prefix_next    = in_prefix_reg;
        prefix_accum_next = prefix_accum_reg;
        if (ip_ok_reg)
        begin
            if (is_digit(ctrl.char_code))
            begin
                if (in_prefix_reg)
                begin
                    if (digit_count_reg == 2'd0)
                    begin
                        prefix_accum_next = PREFIX_W'(digit);
                        digit_count_next  = 2'd1;
                    end
                    else if (digit_count_reg == 2'd1 && prefix_accum_reg != '0)
                    begin
                        prefix_accum_next = prefix_sum[PREFIX_W-1:0];
                        digit_count_next  = 2'd2;
                        if (prefix_sum > 7'(FULL_PREFIX))
                        begin
                            ip_ok_next = 1'b0;
                        end
                    end
                    else
                    begin
                        ip_ok_next = 1'b0;
                    end
                end
                else if (4'(digit_count_reg) >= MAX_OCTET_DIGITS)
                begin
                    ip_ok_next = 1'b0;
                end
                else
                begin
                    octet_accum_next = octet_sum[OCTET_W-1:0];
                    digit_count_next = digit_count_reg + 2'd1;
                    if (octet_sum > 12'd255)
                    begin
                        ip_ok_next = 1'b0;
                    end
                end
            end
            else if (ctrl.char_code == CHAR_DOT)
            begin
                if (in_prefix_reg || digit_count_reg == 2'd0 || octet_index_reg == 2'd3)
                begin
                    ip_ok_next = 1'b0;
                end
                else
                begin
                    packed_next      = {packed_reg[ADDR_W-9:0], octet_accum_reg[7:0]};
                    octet_index_next = octet_index_reg + 2'd1;
                    digit_count_next = 2'd0;
                    octet_accum_next = '0;
                end
            end
            else if (ctrl.char_code == CHAR_SLASH)
            begin
                if (in_prefix_reg || digit_count_reg == 2'd0 || octet_index_reg != 2'd3)
                begin
                    ip_ok_next = 1'b0;
                end
                else
                begin
                    packed_next      = {packed_reg[ADDR_W-9:0], octet_accum_reg[7:0]};
                    in_prefix_next   = 1'b1;
                    digit_count_next = 2'd0;
                    octet_accum_next = '0;
                end
            end
            else
            begin
                ip_ok_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        plain = ip_ok_next && !in_prefix_next && octet_index_next == 2'd3
                && digit_count_next != 2'd0;
        cidr  = plain || (ip_ok_next && in_prefix_next && digit_count_next != 2'd0);
        addr  = in_prefix_next ? packed_next
                               : {packed_next[ADDR_W-9:0], octet_accum_next[7:0]};
        plen  = in_prefix_next ? prefix_accum_next : FULL_PREFIX;
        shamt = FULL_PREFIX - plen;
        host_mask = ~({ADDR_W{1'b1}} << shamt);
        clear = (plen >= FULL_PREFIX) || ((addr & host_mask) == '0);

        result.is_ipv4         = plain;
        result.is_ipv4_cidr    = cidr;
        result.prefix_given    = cidr && in_prefix_next;
        result.prefix_length   = cidr ? plen : '0;
        result.host_bits_clear = cidr && clear;
        result.address_value   = cidr ? addr : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_ok_reg        <= 1'b1;
            octet_index_reg  <= '0;
            digit_count_reg  <= '0;
            octet_accum_reg  <= '0;
            packed_reg       <= '0;
            in_prefix_reg    <= 1'b0;
            prefix_accum_reg <= '0;
        end
        else if (ctrl.step)
        begin
            if (ctrl.last)
            begin
                ip_ok_reg        <= 1'b1;
                octet_index_reg  <= '0;
                digit_count_reg  <= '0;
                octet_accum_reg  <= '0;
                packed_reg       <= '0;
                in_prefix_reg    <= 1'b0;
                prefix_accum_reg <= '0;
            end
            else
            begin
                ip_ok_reg        <= ip_ok_next;
                octet_index_reg  <= octet_index_next;
                digit_count_reg  <= digit_count_next;
                octet_accum_reg  <= octet_accum_next;
                packed_reg       <= packed_next;
                in_prefix_reg    <= in_prefix_next;
                prefix_accum_reg <= prefix_accum_next;
            end
        end
    end

endmodule

`default_nettype wire

/* src/icdv_name_unit.sv */
// Hostname and wildcard hostname tracker with its end-of-string verdict.
`default_nettype none

module icdv_name_unit
    import icdv_pkg::*;
#(
    parameter int MAX_NAME_LEN  = MAX_NAME_LEN_DEF,
    parameter int MAX_LABEL_LEN = MAX_LABEL_LEN_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire step_t ctrl,
    output name_result_t result
);

    localparam int BC_W = $clog2(MAX_NAME_LEN + 2);
    localparam int LL_W = $clog2(MAX_LABEL_LEN + 2);
    localparam logic [BC_W-1:0] NAME_LIMIT  = BC_W'(MAX_NAME_LEN);
    localparam logic [LL_W-1:0] LABEL_LIMIT = LL_W'(MAX_LABEL_LEN);

    logic [BC_W-1:0] byte_count_reg, byte_count_next;
    logic [LL_W-1:0] label_len_reg, label_len_next;
    logic [1:0]      first_class_reg, first_class_next;
    logic [1:0]      prev_class_reg, prev_class_next;
    logic            has_star_reg, has_star_next;
    logic            dot_seen_reg, dot_seen_next;
    logic            domain_ok_reg, domain_ok_next;
    logic            wildcard_ok_reg, wildcard_ok_next;

    logic [7:0] c;
    logic       is_letter;
    logic       is_class;
    logic [1:0] cls;
    logic       final_ok;

    assign c = ctrl.char_code;
    assign is_letter = (c >= CHAR_LC_A && c <= CHAR_LC_Z) || (c >= CHAR_UC_A && c <= CHAR_UC_Z);
    assign is_class  = is_letter || is_digit(c) || c == CHAR_HYPHEN || c == CHAR_STAR;

    always_comb
    begin
        if (is_letter)
        begin
            cls = CLS_LETTER;
        end
        else if (is_digit(c))
        begin
            cls = CLS_DIGIT;
        end
        else if (c == CHAR_HYPHEN)
        begin
            cls = CLS_HYPHEN;
        end
        else
        begin
            cls = CLS_STAR;
        end
    end

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        label_len_next   = label_len_reg;
        first_class_next = first_class_reg;
        prev_class_next  = prev_class_reg;
        has_star_next    = has_star_reg;
        dot_seen_next    = dot_seen_reg;
        domain_ok_next   = domain_ok_reg;
        wildcard_ok_next = wildcard_ok_reg;

        if (byte_count_reg <= NAME_LIMIT)
        begin
            byte_count_next = byte_count_reg + BC_W'(1);
        end

        if (c == CHAR_DOT)
        begin
            if (label_len_reg == '0 || prev_class_reg == CLS_HYPHEN
                || label_len_reg > LABEL_LIMIT)
            begin
                domain_ok_next   = 1'b0;
                wildcard_ok_next = 1'b0;
            end
            dot_seen_next  = 1'b1;
            label_len_next = '0;
            has_star_next  = 1'b0;
        end
        else if (!is_class)
        begin
            domain_ok_next   = 1'b0;
            wildcard_ok_next = 1'b0;
        end
        else
        begin
            if (cls == CLS_STAR)
            begin
                domain_ok_next = 1'b0;
                has_star_next  = 1'b1;
            end
            if (label_len_reg == '0)
            begin
                first_class_next = cls;
                if (cls == CLS_HYPHEN)
                begin
                    domain_ok_next   = 1'b0;
                    wildcard_ok_next = 1'b0;
                end
            end
            if (label_len_reg <= LABEL_LIMIT)
            begin
                label_len_next = label_len_reg + LL_W'(1);
            end
            prev_class_next = cls;
        end
    end

    always_comb
    begin
        final_ok = dot_seen_next && label_len_next >= LL_W'(2)
                   && first_class_next == CLS_LETTER && prev_class_next == CLS_LETTER
                   && !has_star_next && byte_count_next <= NAME_LIMIT;
        result.is_domain          = domain_ok_next && final_ok;
        result.is_wildcard_domain = wildcard_ok_next && final_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            label_len_reg   <= '0;
            first_class_reg <= CLS_LETTER;
            prev_class_reg  <= CLS_LETTER;
            has_star_reg    <= 1'b0;
            dot_seen_reg    <= 1'b0;
            domain_ok_reg   <= 1'b1;
            wildcard_ok_reg <= 1'b1;
        end
        else if (ctrl.step)
        begin
            if (ctrl.last)
            begin
                byte_count_reg  <= '0;
                label_len_reg   <= '0;
                first_class_reg <= CLS_LETTER;
                prev_class_reg  <= CLS_LETTER;
                has_star_reg    <= 1'b0;
                dot_seen_reg    <= 1'b0;
                domain_ok_reg   <= 1'b1;
                wildcard_ok_reg <= 1'b1;
            end
            else
            begin
                byte_count_reg  <= byte_count_next;
                label_len_reg   <= label_len_next;
                first_class_reg <= first_class_next;
                prev_class_reg  <= prev_class_next;
                has_star_reg    <= has_star_next;
                dot_seen_reg    <= dot_seen_next;
                domain_ok_reg   <= domain_ok_next;
                wildcard_ok_reg <= wildcard_ok_next;
            end
        end
    end

endmodule

`default_nettype wire

/* src/ipv4_cidr_domain_validator.sv */
// Top level of the byte-serial IPv4, CIDR and hostname syntax checker.
//
// A string enters on the s_ stream one byte per item, with s_tlast set on its
// final byte. Bytes without s_tlast produce nothing; the final byte produces
// one result item on the m_ stream carrying the address and hostname verdicts,
// after which the checker starts over for the next string.
// Each accepted byte is held in an input register, then updates the address
// and hostname trackers while the verdict is written to the result register.
// The result of a final byte passes through the input and result registers;
// one byte is taken every cycle while no result is held back by m_tready.
// If the receiver holds m_tready low while a result waits, the input register
// fills and s_tready drops until the result is taken; nothing is lost.
// Reset clears the valid bits of both registers and returns every tracker to
// the start of a string.
`default_nettype none

module ipv4_cidr_domain_validator
    import icdv_pkg::*;
#(
    parameter int MAX_NAME_LEN  = MAX_NAME_LEN_DEF,
    parameter int MAX_LABEL_LEN = MAX_LABEL_LEN_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    // Fields from bit 0: char_code[7:0].
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tlast,
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    // Fields from bit 0: is_ipv4, is_ipv4_cidr, prefix_given, prefix_length[5:0],
    // host_bits_clear, address_value[31:0], is_domain, is_wildcard_domain, zero pad.
    output      logic [OUT_TDATA_W-1:0] m_tdata
);

    logic                   in_valid_reg;
    logic [CHAR_W-1:0]      in_char_reg;
    logic                   in_last_reg;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   advance;
    step_t                  ctrl;
    ip_result_t             ip_res;
    name_result_t           name_res;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign ctrl.step      = in_valid_reg && advance;
    assign ctrl.last      = in_last_reg;
    assign ctrl.char_code = in_char_reg;

    icdv_ip_unit u_ip
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .result (ip_res)
    );

    icdv_name_unit
    #(
        .MAX_NAME_LEN  (MAX_NAME_LEN),
        .MAX_LABEL_LEN (MAX_LABEL_LEN)
    )
    u_name
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .result (name_res)
    );

    assign out_data_next = {4'b0000,
                            name_res.is_wildcard_domain,
                            name_res.is_domain,
                            ip_res.address_value,
                            ip_res.host_bits_clear,
                            ip_res.prefix_length,
                            ip_res.prefix_given,
                            ip_res.is_ipv4_cidr,
                            ip_res.is_ipv4};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= ctrl.step && in_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata[CHAR_W-1:0];
            in_last_reg <= s_tlast;
        end
        if (ctrl.step && in_last_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

/* tb/tb_ipv4_cidr_domain_validator.sv */
// Self-checking testbench for the byte-serial IPv4, CIDR and hostname checker.
`timescale 1ns / 100ps

module tb_ipv4_cidr_domain_validator;
    import icdv_pkg::*;

    typedef struct packed {
        logic        wild;
        logic        dom;
        logic [31:0] addr;
        logic        clear;
        logic [5:0]  plen;
        logic        given;
        logic        cidr;
        logic        plain;
    } verdict_t;

    class string_verdict_board;
        verdict_t    pending_verdicts[$];
        int          failures;
        int          verdicts_checked;
        int          quads_seen;
        int          prefixed_seen;
        int          names_seen;
        int          wild_seen;

        logic [7:0]  byte_cnt;
        logic        ip_ok;
        logic [1:0]  octet_idx;
        logic [1:0]  digit_cnt;
        logic [9:0]  octet_acc;
        logic [31:0] addr_acc;
        logic        in_prefix;
        logic [6:0]  prefix_acc;
        logic [6:0]  label_len;
        logic [1:0]  first_cls;
        logic [1:0]  prev_cls;
        logic        label_star;
        logic        dot_seen;
        logic        name_ok;
        logic        wild_ok;

        function new();
            failures = 0;
            verdicts_checked = 0;
            quads_seen = 0;
            prefixed_seen = 0;
            names_seen = 0;
            wild_seen = 0;
            restart();
        endfunction

        function void restart();
            byte_cnt = '0;
            ip_ok = 1'b1;
            octet_idx = '0;
            digit_cnt = '0;
            octet_acc = '0;
            addr_acc = '0;
            in_prefix = 1'b0;
            prefix_acc = '0;
            label_len = '0;
            first_cls = CLS_LETTER;
            prev_cls = CLS_LETTER;
            label_star = 1'b0;
            dot_seen = 1'b0;
            name_ok = 1'b1;
            wild_ok = 1'b1;
        endfunction

        function void track_address(logic [7:0] c);
            int d;
            if (!ip_ok)
                return;
            if (c >= CHAR_0 && c <= CHAR_9) begin
                d = c - CHAR_0;
                if (in_prefix) begin
                    if (digit_cnt == 0) begin
                        prefix_acc = d;
                        digit_cnt = 1;
                    end
                    else if (digit_cnt == 1 && prefix_acc != 0) begin
                        prefix_acc = prefix_acc * 10 + d;
                        digit_cnt = 2;
                        if (prefix_acc > 32)
                            ip_ok = 1'b0;
                    end
                    else
                        ip_ok = 1'b0;
                end
                else if (digit_cnt >= 3)
                    ip_ok = 1'b0;
                else begin
                    octet_acc = octet_acc * 10 + d;
                    digit_cnt = digit_cnt + 1;
                    if (octet_acc > 255)
                        ip_ok = 1'b0;
                end
            end
            else if (c == CHAR_DOT) begin
                if (in_prefix || digit_cnt == 0 || octet_idx >= 3)
                    ip_ok = 1'b0;
                else begin
                    addr_acc = {addr_acc[23:0], octet_acc[7:0]};
                    octet_idx = octet_idx + 1;
                    digit_cnt = 0;
                    octet_acc = 0;
                end
            end
            else if (c == CHAR_SLASH) begin
                if (in_prefix || digit_cnt == 0 || octet_idx != 3)
                    ip_ok = 1'b0;
                else begin
                    addr_acc = {addr_acc[23:0], octet_acc[7:0]};
                    in_prefix = 1'b1;
                    digit_cnt = 0;
                    octet_acc = 0;
                end
            end
            else
                ip_ok = 1'b0;
        endfunction

        function void track_name(logic [7:0] c);
            logic [1:0] cls;
            if ((c >= CHAR_LC_A && c <= CHAR_LC_Z) || (c >= CHAR_UC_A && c <= CHAR_UC_Z))
                cls = CLS_LETTER;
            else if (c >= CHAR_0 && c <= CHAR_9)
                cls = CLS_DIGIT;
            else if (c == CHAR_HYPHEN)
                cls = CLS_HYPHEN;
            else if (c == CHAR_STAR)
                cls = CLS_STAR;
            else if (c == CHAR_DOT) begin
                if (label_len == 0 || prev_cls == CLS_HYPHEN || label_len > MAX_LABEL_LEN_DEF)
                begin
                    name_ok = 1'b0;
                    wild_ok = 1'b0;
                end
                dot_seen = 1'b1;
                label_len = 0;
                label_star = 1'b0;
                return;
            end
            else begin
                name_ok = 1'b0;
                wild_ok = 1'b0;
                return;
            end
            if (cls == CLS_STAR) begin
                name_ok = 1'b0;
                label_star = 1'b1;
            end
            if (label_len == 0) begin
                first_cls = cls;
                if (cls == CLS_HYPHEN) begin
                    name_ok = 1'b0;
                    wild_ok = 1'b0;
                end
            end
            if (label_len <= MAX_LABEL_LEN_DEF)
                label_len = label_len + 1;
            prev_cls = cls;
        endfunction

        function void take_byte(logic [7:0] c, logic last);
            verdict_t   v;
            logic       plain;
            logic       cidr;
            logic       clr;
            logic       final_ok;
            logic [31:0] addr;
            logic [6:0] plen;
            if (byte_cnt <= MAX_NAME_LEN_DEF)
                byte_cnt = byte_cnt + 1;
            track_address(c);
            track_name(c);
            if (!last)
                return;
            plain = ip_ok && !in_prefix && octet_idx == 3 && digit_cnt > 0;
            cidr = plain || (ip_ok && in_prefix && digit_cnt > 0);
            addr = in_prefix ? addr_acc : {addr_acc[23:0], octet_acc[7:0]};
            plen = in_prefix ? prefix_acc : 7'd32;
            if (plen >= 32)
                clr = 1'b1;
            else if (plen == 0)
                clr = (addr == 0);
            else
                clr = (addr & ~(32'hFFFF_FFFF << (32 - plen))) == 0;
            final_ok = dot_seen && label_len >= 2 && first_cls == CLS_LETTER &&
                       prev_cls == CLS_LETTER && !label_star && byte_cnt <= MAX_NAME_LEN_DEF;
            v.plain = plain;
            v.cidr  = cidr;
            v.given = cidr && in_prefix;
            v.plen  = cidr ? plen[5:0] : 6'd0;
            v.clear = cidr && clr;
            v.addr  = cidr ? addr : 32'd0;
            v.dom   = name_ok && final_ok;
            v.wild  = wild_ok && final_ok;
            pending_verdicts.push_back(v);
            restart();
        endfunction

        function void compare_field(string label, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
                failures++;
            end
        endfunction

        function void check_verdict(logic [OUT_TDATA_W-1:0] d);
            verdict_t e;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with no verdict pending, expected none, actual %h",
                         $time, d);
                failures++;
                return;
            end
            e = pending_verdicts.pop_front();
            compare_field("is_ipv4", e.plain, d[0]);
            compare_field("is_ipv4_cidr", e.cidr, d[1]);
            compare_field("prefix_given", e.given, d[2]);
            compare_field("prefix_length", e.plen, d[8:3]);
            compare_field("host_bits_clear", e.clear, d[9]);
            compare_field("address_value", e.addr, d[41:10]);
            compare_field("is_domain", e.dom, d[42]);
            compare_field("is_wildcard_domain", e.wild, d[43]);
            compare_field("pad", 32'd0, d[47:44]);
            verdicts_checked++;
            quads_seen += e.plain;
            prefixed_seen += e.given;
            names_seen += e.dom;
            wild_seen += e.wild;
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tready = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;

    string_verdict_board    board;
    bit                     calm = 1'b0;
    int                     bytes_sent = 0;
    int                     strings_sent = 0;
    logic [7:0]             text[$];

    ipv4_cidr_domain_validator DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_verdict(m_tdata);
            if (s_tvalid && s_tready)
                board.take_byte(s_tdata[7:0], s_tlast);
        end
    end

    function automatic logic [7:0] random_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? CHAR_LC_A + r : CHAR_UC_A + (r - 26);
    endfunction

    function automatic logic [7:0] random_digit();
        return CHAR_0 + $urandom_range(0, 9);
    endfunction

    function automatic int pick_octet();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 255;
            2: return $urandom_range(250, 255);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 25)
            gap = $urandom_range(1, 2);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            send_byte(text[i], i == text.size() - 1);
        strings_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endtask

    task automatic run_text(input string s);
        text.delete();
        push_text(s);
        send_text();
    endtask

    task automatic push_octet(input int v);
        bit pad;
        pad = ($urandom_range(0, 3) == 0);
        if (pad || v >= 100)
            text.push_back(CHAR_0 + v / 100);
        if (pad || v >= 10)
            text.push_back(CHAR_0 + (v / 10) % 10);
        text.push_back(CHAR_0 + v % 10);
    endtask

    task automatic push_label(input int len, input bit final_lbl, input bit star_ok);
        logic [7:0] c;
        for (int i = 0; i < len; i++)
        begin
            if (final_lbl && (i == 0 || i == len - 1))
                c = random_letter();
            else if (i == 0 || i == len - 1)
            begin
                case ($urandom_range(0, star_ok ? 2 : 1))
                    0: c = random_letter();
                    1: c = random_digit();
                    default: c = CHAR_STAR;
                endcase
            end
            else
            begin
                case ($urandom_range(0, star_ok ? 3 : 2))
                    0: c = random_letter();
                    1: c = random_digit();
                    2: c = CHAR_HYPHEN;
                    default: c = CHAR_STAR;
                endcase
            end
            text.push_back(c);
        end
    endtask

    task automatic push_long_name(input int total);
        int remaining;
        remaining = total;
        while (remaining > 67)
        begin
            push_label(63, 1'b0, 1'b0);
            text.push_back(CHAR_DOT);
            remaining -= 64;
        end
        if (remaining - 3 <= 63)
        begin
            push_label(remaining - 3, 1'b0, 1'b0);
            text.push_back(CHAR_DOT);
            push_label(2, 1'b1, 1'b0);
        end
        else
        begin
            push_label(remaining - 4, 1'b0, 1'b0);
            text.push_back(CHAR_DOT);
            push_label(3, 1'b1, 1'b0);
        end
    endtask

    task automatic build_random_string();
        int          r;
        int          plen;
        int          pos;
        int          labels;
        bit          broken;
        logic [7:0]  c;
        logic [31:0] addr;
        text.delete();
        broken = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 48)
        begin
            addr = {8'(pick_octet()), 8'(pick_octet()), 8'(pick_octet()), 8'(pick_octet())};
            plen = 32;
            if (r >= 18)
            begin
                case ($urandom_range(0, 4))
                    0: plen = 0;
                    1: plen = 32;
                    2: plen = $urandom_range(33, 99);
                    default: plen = $urandom_range(0, 32);
                endcase
                if ($urandom_range(0, 1) == 1)
                begin
                    if (plen == 0)
                        addr = '0;
                    else if (plen < 32)
                        addr = addr & (32'hFFFF_FFFF << (32 - plen));
                end
            end
            for (int k = 0; k < 4; k++)
            begin
                push_octet(addr[31 - 8 * k -: 8]);
                if (k < 3)
                    text.push_back(CHAR_DOT);
            end
            if (r >= 18)
            begin
                text.push_back(CHAR_SLASH);
                if (plen >= 10)
                    text.push_back(CHAR_0 + plen / 10);
                text.push_back(CHAR_0 + plen % 10);
            end
            broken = (r >= 36);
        end
        else if (r < 88)
        begin
            labels = $urandom_range(1, 4);
            for (int k = 0; k < labels; k++)
            begin
                push_label(($urandom_range(0, 19) == 0) ? $urandom_range(60, 64)
                                                        : $urandom_range(1, 8),
                           1'b0, r >= 66 && r < 76);
                text.push_back(CHAR_DOT);
            end
            push_label($urandom_range(2, 6), 1'b1, 1'b0);
            broken = (r >= 76);
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                text.push_back($urandom_range(0, 255));
        end
        if (broken)
        begin
            case ($urandom_range(0, 5))
                0: c = CHAR_DOT;
                1: c = CHAR_SLASH;
                2: c = CHAR_HYPHEN;
                3: c = CHAR_STAR;
                4: c = random_digit();
                default: c = random_letter();
            endcase
            pos = $urandom_range(0, text.size() - 1);
            case ($urandom_range(0, 3))
                0: text[pos] = c;
                1: text[pos] = $urandom_range(0, 255);
                2: if (text.size() > 1) void'(text.pop_back());
                default: text.push_back(c);
            endcase
        end
    endtask

    task automatic wait_for_verdicts();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int n;
        int wait_cycles;
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_text("0.0.0.0");
        run_text("255.255.255.255");
        run_text("256.1.1.1");
        run_text("001.02.3.004");
        run_text("1234.1.1.1");
        run_text("1.2.3");
        run_text("1.2.3.4.5");
        run_text("0.0.0.0/0");
        run_text("1.2.3.4/0");
        run_text("10.0.0.0/8");
        run_text("10.0.0.1/8");
        run_text("1.2.3.4/32");
        run_text("1.2.3.4/33");
        run_text("1.2.3.4/01");
        run_text("1.2.3.4/");
        run_text("a");
        run_text("7");
        run_text("ab.cd");
        run_text("a-b.Zz");
        run_text("-a.co");
        run_text("a..bc");
        run_text("*.ex.com");
        run_text("a.b2");
        text.delete();
        push_label(63, 1'b0, 1'b0);
        push_text(".com");
        send_text();
        text.delete();
        push_label(64, 1'b0, 1'b0);
        push_text(".com");
        send_text();
        text.delete();
        push_text("a");
        text.push_back(8'hFF);
        push_text("b.cd");
        send_text();
        calm = 1'b1;
        text.delete();
        push_long_name(253);
        send_text();
        text.delete();
        push_long_name(254);
        send_text();
        calm = 1'b0;
        wait_for_verdicts();

        n = 0;
        while (n < 10)
        begin
            build_random_string();
            send_text();
            if (n % 5 == 4)
                wait_for_verdicts();
            n++;
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        wait_cycles = 0;
        do
        begin
            @(posedge clk);
            wait_cycles++;
        end
        while (board.pending() != 0 && wait_cycles < 5000);
        repeat (10) @(posedge clk);
        if (board.pending() != 0)
        begin
            $display("%0t: %0d verdicts never arrived", $time, board.pending());
            board.failures++;
        end

        $display("Sent %0d strings in %0d bytes; %0d verdicts checked.",
                 strings_sent, bytes_sent, board.verdicts_checked);
        $display("Valid: %0d dotted quads, %0d prefixed, %0d hostnames, %0d wildcard names.",
                 board.quads_seen, board.prefixed_seen, board.names_seen, board.wild_seen);
        if (board.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
src/icdv_pkg.sv
src/icdv_ip_unit.sv
src/icdv_name_unit.sv
src/ipv4_cidr_domain_validator.sv
tb/tb_ipv4_cidr_domain_validator.sv
